// File: sv/assert_macros.svh
// shared assertion macros, clocked on i_clk with the synchronous reset masked
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define CQZ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// property checked in the cycle after a trigger
`define CQZ_ASSERT_NEXT(label, cond, prop, msg) \
    `CQZ_ASSERT(label, (cond) |=> (prop), msg)

`endif

// File: sv/cqz_pkg.sv
`timescale 1ns / 1ps
package cqz_pkg;

    // field and datapath widths
    localparam int COEF_W     = 16;
    localparam int ENTRY_W    = 8;
    localparam int SCALE_W    = 16;
    localparam int DEN_W      = ENTRY_W + SCALE_W;
    localparam int PROD_W     = COEF_W + DEN_W;
    localparam int QUOT_W     = 16;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = QUOT_W / DIV_STEPS;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    // request kinds
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_PROC = 1'b1;

    // channel code that selects the luminance table
    localparam logic [1:0] CH_LUMA = 2'd0;

    // register index, taken from paddr bit 2
    localparam logic REG_QUALITY   = 1'b0;
    localparam logic REG_DIRECTION = 1'b1;

    // direction codes
    localparam logic DIR_QUANT   = 1'b0;
    localparam logic DIR_DEQUANT = 1'b1;

    localparam logic [SCALE_W-1:0] QUALITY_RESET = 16'd256;

    // saturation magnitudes
    localparam logic [COEF_W-1:0] MAG_POS_LIMIT = 16'h7FFF;
    localparam logic [COEF_W-1:0] MAG_NEG_LIMIT = 16'h8000;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SAT      = 2'd1,
        ST_ZERO_DIV = 2'd2
    } t_status;

    // side information that rides along the divider
    typedef struct packed {
        logic              neg;
        logic              big;
        logic              use_alt;
        logic [COEF_W-1:0] alt_value;
        t_status           alt_status;
    } t_ctx;

    // restoring divider state
    typedef struct packed {
        logic [DEN_W-1:0]  r;
        logic [QUOT_W-1:0] n;
        logic [QUOT_W-1:0] q;
        logic [DEN_W-1:0]  d;
    } t_div;

    // two's complement of a magnitude when the sign is set
    function automatic logic [COEF_W-1:0] apply_sign(input logic neg,
                                                     input logic [COEF_W-1:0] mag);
        apply_sign = neg ? (COEF_W'(0) - mag) : mag;
    endfunction

endpackage

// File: sv/cqz_req_if.sv
`timescale 1ns / 1ps
interface cqz_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [1:0]         channel;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [15:0] coefficient;
    logic [7:0]         table_word;

    modport source (
        output valid, req_type, channel, row, col, coefficient, table_word,
        input  ready
    );
    modport sink (
        input  valid, req_type, channel, row, col, coefficient, table_word,
        output ready
    );
endinterface

// File: sv/cqz_res_if.sv
`timescale 1ns / 1ps
interface cqz_res_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] result_value;
    logic [1:0]         status;

    modport source (
        output valid, result_value, status,
        input  ready
    );
    modport sink (
        input  valid, result_value, status,
        output ready
    );
endinterface

// File: sv/cqz_ram.sv
`timescale 1ns / 1ps
module cqz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/cqz_div_stage.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cqz_div_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  cqz_pkg::t_ctx i_ctx,
    input  cqz_pkg::t_div i_div,
    output logic          o_valid,
    output cqz_pkg::t_ctx o_ctx,
    output cqz_pkg::t_div o_div
);
    import cqz_pkg::*;

    t_div           w_step  [DIV_STEPS+1];
    logic [DEN_W:0] w_trial [DIV_STEPS];
    logic           r_valid;
    t_ctx           r_ctx;
    t_div           r_div;

    // restoring steps, one quotient bit each
    always_comb begin
        w_step[0] = i_div;
        for (int k = 0; k < DIV_STEPS; k++) begin
            w_trial[k]     = {w_step[k].r, w_step[k].n[QUOT_W-1]};
            w_step[k+1]    = w_step[k];
            w_step[k+1].n  = {w_step[k].n[QUOT_W-2:0], 1'b0};
            if (w_trial[k] >= {1'b0, w_step[k].d}) begin
                w_step[k+1].r = DEN_W'(w_trial[k] - {1'b0, w_step[k].d});
                w_step[k+1].q = {w_step[k].q[QUOT_W-2:0], 1'b1};
            end else begin
                w_step[k+1].r = w_trial[k][DEN_W-1:0];
                w_step[k+1].q = {w_step[k].q[QUOT_W-2:0], 1'b0};
            end
        end
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctx <= i_ctx;
            r_div <= w_step[DIV_STEPS];
        end
    end

    assign o_valid = r_valid;
    assign o_ctx   = r_ctx;
    assign o_div   = r_div;

    `CQZ_ASSERT_NEXT(a_stall_holds_valid, !i_en, $stable(r_valid), "div stage valid moved in stall")
    `CQZ_ASSERT_NEXT(a_stall_holds_quot, r_valid && !i_en, $stable(r_div.q), "div stage quotient moved in stall")
    `CQZ_ASSERT(a_rem_below_div, !(r_valid && !r_ctx.big && !r_ctx.use_alt) || r_div.r < r_div.d, "partial remainder not below divisor")

endmodule

// File: sv/coefficient_quantizer_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Scaled-table coefficient quantizer. Load words fill a luminance and a chrominance
// TABLE_DIM x TABLE_DIM table; process words divide (direction 0) or multiply
// (direction 1) the coefficient by entry * quality_scale / 256, round half away from
// zero and saturate to 16-bit signed with a status code. One word is taken every clock
// when the output is drained. The table is read at the edge that accepts a process word,
// then the step multiply, the product multiply, the divider setup, eight restoring
// divider stages of two quotient bits each and the output register follow, each of them
// registered. When the output stalls, one more result parks in a skid entry and the
// whole pipeline then holds. The tables need no clearing pass after reset, so words are
// taken from the first cycle out of reset; reading a table entry that was never loaded
// returns an unspecified value.
module coefficient_quantizer_core #(
    parameter int TABLE_DIM = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    cqz_req_if.sink                     i_req,
    cqz_res_if.source                   o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cqz_pkg::PADDR_W-1:0] paddr,
    input  logic [cqz_pkg::PDATA_W-1:0] pwdata,
    output logic [cqz_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import cqz_pkg::*;

    localparam int PLANE  = TABLE_DIM * TABLE_DIM;
    localparam int DEPTH  = 2 * PLANE;
    localparam int ADDR_W = $clog2(DEPTH);

    // configuration registers
    logic [SCALE_W-1:0] r_quality_scale;
    logic               r_direction;

    // front stages
    logic               w_en;
    logic               w_accept;
    logic               w_in_range;
    logic [ADDR_W-1:0]  w_addr;
    logic [ENTRY_W-1:0] w_rdata;
    logic               r_s1_valid;
    logic               r_s1_oor;
    logic [COEF_W-1:0]  r_s1_coef;
    logic [ENTRY_W-1:0] w_entry;
    logic [COEF_W-1:0]  w_amag;
    logic               r_s2_valid;
    logic [DEN_W-1:0]   r_s2_den;
    logic [COEF_W-1:0]  r_s2_amag;
    logic               r_s2_neg;
    logic               r_s3_valid;
    logic [PROD_W-1:0]  r_s3_prod;
    logic [DEN_W-1:0]   r_s3_den;
    logic [COEF_W-1:0]  r_s3_amag;
    logic               r_s3_neg;

    // alternate result and divider setup
    logic [PROD_W:0]    w_dq_sum;
    logic [PROD_W-8:0]  w_dq;
    logic [PROD_W-8:0]  w_dq_limit;
    logic               w_dq_sat;
    logic               w_zero_den;
    t_ctx               w_s4_ctx;
    t_div               w_s4_div;
    logic               r_s4_valid;
    t_ctx               r_s4_ctx;
    t_div               r_s4_div;

    // divider chain
    logic               w_vld [DIV_STAGES+1];
    t_ctx               w_ctx [DIV_STAGES+1];
    t_div               w_div [DIV_STAGES+1];

    // finishing and output
    t_ctx               w_tl_ctx;
    t_div               w_tl_div;
    logic               w_rnd;
    logic [QUOT_W:0]    w_qr;
    logic [QUOT_W:0]    w_q_limit;
    logic               w_q_sat;
    logic [COEF_W-1:0]  w_fin_value;
    t_status            w_fin_status;
    logic               w_out_fire;
    logic               r_out_valid;
    logic [COEF_W-1:0]  r_out_value;
    t_status            r_out_status;
    logic               r_skid_valid;
    logic [COEF_W-1:0]  r_skid_value;
    t_status            r_skid_status;

    // config port, register index from the word address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quality_scale <= QUALITY_RESET;
            r_direction     <= DIR_QUANT;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_QUALITY:   r_quality_scale <= pwdata[SCALE_W-1:0];
                REG_DIRECTION: r_direction     <= pwdata[0];
                default:       r_direction     <= r_direction;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_QUALITY:   prdata = {(PDATA_W-SCALE_W)'(0), r_quality_scale};
            REG_DIRECTION: prdata = {(PDATA_W-1)'(0), r_direction};
            default:       prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // whole pipeline moves unless the skid entry is occupied
    assign w_en        = !r_skid_valid;
    assign i_req.ready = w_en;
    assign w_accept    = i_req.valid && w_en;

    // table address: plane, then row-major position
    assign w_in_range = (int'(i_req.row) < TABLE_DIM) && (int'(i_req.col) < TABLE_DIM);
    assign w_addr = ADDR_W'(((i_req.channel != CH_LUMA) ? PLANE : 0)
                            + int'(i_req.row) * TABLE_DIM + int'(i_req.col));

    cqz_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_accept && i_req.req_type == REQ_LOAD && w_in_range),
        .i_waddr (w_addr),
        .i_wdata (i_req.table_word),
        .i_re    (w_accept && i_req.req_type == REQ_PROC),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    // stage 1: table read in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= w_accept && i_req.req_type == REQ_PROC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_oor  <= !w_in_range;
            r_s1_coef <= i_req.coefficient;
        end
    end

    // stage 2: step = entry * scale, coefficient magnitude
    assign w_entry = r_s1_oor ? '0 : w_rdata;
    assign w_amag  = r_s1_coef[COEF_W-1] ? (COEF_W'(0) - r_s1_coef) : r_s1_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_den  <= {(DEN_W-ENTRY_W)'(0), w_entry} * {(DEN_W-SCALE_W)'(0), r_quality_scale};
            r_s2_amag <= w_amag;
            r_s2_neg  <= r_s1_coef[COEF_W-1];
        end
    end

    // stage 3: dequantize product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_en) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_prod <= {(PROD_W-COEF_W)'(0), r_s2_amag} * {(PROD_W-DEN_W)'(0), r_s2_den};
            r_s3_den  <= r_s2_den;
            r_s3_amag <= r_s2_amag;
            r_s3_neg  <= r_s2_neg;
        end
    end

    // stage 4: dequantize or zero-divisor result, divider setup
    assign w_dq_sum   = {1'b0, r_s3_prod} + (PROD_W+1)'(128);
    assign w_dq       = w_dq_sum[PROD_W:8];
    assign w_dq_limit = r_s3_neg ? (PROD_W-7)'(MAG_NEG_LIMIT) : (PROD_W-7)'(MAG_POS_LIMIT);
    assign w_dq_sat   = w_dq > w_dq_limit;
    assign w_zero_den = r_s3_den == '0;

    always_comb begin
        w_s4_ctx.neg     = r_s3_neg;
        w_s4_ctx.big     = r_s3_den <= {(DEN_W-8)'(0), r_s3_amag[COEF_W-1:8]};
        w_s4_ctx.use_alt = (r_direction == DIR_DEQUANT) || w_zero_den;
        if (r_direction == DIR_DEQUANT) begin
            w_s4_ctx.alt_value  = apply_sign(r_s3_neg, w_dq_sat ? w_dq_limit[COEF_W-1:0]
                                                                : w_dq[COEF_W-1:0]);
            w_s4_ctx.alt_status = w_dq_sat ? ST_SAT : ST_OK;
        end else begin
            if (r_s3_amag == '0) begin
                w_s4_ctx.alt_value = '0;
            end else begin
                w_s4_ctx.alt_value = r_s3_neg ? MAG_NEG_LIMIT : MAG_POS_LIMIT;
            end
            w_s4_ctx.alt_status = ST_ZERO_DIV;
        end
        w_s4_div.r = {(DEN_W-8)'(0), r_s3_amag[COEF_W-1:8]};
        w_s4_div.n = {r_s3_amag[7:0], 8'd0};
        w_s4_div.q = '0;
        w_s4_div.d = r_s3_den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (w_en) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_ctx <= w_s4_ctx;
            r_s4_div <= w_s4_div;
        end
    end

    // divider pipeline
    assign w_vld[0] = r_s4_valid;
    assign w_ctx[0] = r_s4_ctx;
    assign w_div[0] = r_s4_div;

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        cqz_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_vld[g]),
            .i_ctx   (w_ctx[g]),
            .i_div   (w_div[g]),
            .o_valid (w_vld[g+1]),
            .o_ctx   (w_ctx[g+1]),
            .o_div   (w_div[g+1])
        );
    end

    // rounding from the remainder, then saturation
    assign w_tl_ctx  = w_ctx[DIV_STAGES];
    assign w_tl_div  = w_div[DIV_STAGES];
    assign w_rnd     = {w_tl_div.r, 1'b0} >= {1'b0, w_tl_div.d};
    assign w_qr      = {1'b0, w_tl_div.q} + (QUOT_W+1)'(w_rnd);
    assign w_q_limit = w_tl_ctx.neg ? (QUOT_W+1)'(MAG_NEG_LIMIT) : (QUOT_W+1)'(MAG_POS_LIMIT);
    assign w_q_sat   = w_tl_ctx.big || (w_qr > w_q_limit);

    always_comb begin
        if (w_tl_ctx.use_alt) begin
            w_fin_value  = w_tl_ctx.alt_value;
            w_fin_status = w_tl_ctx.alt_status;
        end else begin
            w_fin_value  = apply_sign(w_tl_ctx.neg, w_q_sat ? w_q_limit[COEF_W-1:0]
                                                            : w_qr[COEF_W-1:0]);
            w_fin_status = w_q_sat ? ST_SAT : ST_OK;
        end
    end

    // output register with one skid entry behind it
    assign w_out_fire = r_out_valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!w_en) begin
            if (w_out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_vld[DIV_STAGES]) begin
            if (!r_out_valid || w_out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_en) begin
            if (w_out_fire) begin
                r_out_value  <= r_skid_value;
                r_out_status <= r_skid_status;
            end
        end else if (w_vld[DIV_STAGES]) begin
            if (!r_out_valid || w_out_fire) begin
                r_out_value  <= w_fin_value;
                r_out_status <= w_fin_status;
            end else begin
                r_skid_value  <= w_fin_value;
                r_skid_status <= w_fin_status;
            end
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.result_value = r_out_value;
    assign o_res.status       = r_out_status;

    `CQZ_ASSERT(a_skid_needs_out, !r_skid_valid || r_out_valid,
                "skid word held with empty output register")
    `CQZ_ASSERT_NEXT(a_load_no_result, w_accept && i_req.req_type == REQ_LOAD,
                     !r_s1_valid, "load word entered the datapath")
    `CQZ_ASSERT_NEXT(a_freeze_holds_tail, !w_en, $stable(w_vld[DIV_STAGES]),
                     "divider tail moved while frozen")
    `CQZ_ASSERT(a_sat_at_limit, !(r_out_valid && r_out_status == ST_SAT)
                || r_out_value == MAG_POS_LIMIT || r_out_value == MAG_NEG_LIMIT,
                "saturated word not at a limit")

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import cqz_pkg::*;

    localparam int          TABLE_DIM      = 8;
    localparam int          SETTLE_CYCLES  = 24;
    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          PHASE_COUNT    = 14;
    localparam int          PHASE_WORDS    = 100;
    localparam logic [1:0]  CH_CB          = 2'd1;
    localparam logic [1:0]  CH_CR          = 2'd2;

    typedef struct {
        logic [15:0] value;
        t_status     status;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    cqz_req_if req_if ();
    cqz_res_if res_if ();

    coefficient_quantizer_core #(
        .TABLE_DIM(TABLE_DIM)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // local copy of the block state and settings
    logic [7:0]  table_copy   [2][TABLE_DIM*TABLE_DIM];
    logic [15:0] quality_copy;
    logic        direction_copy;

    t_outcome pending_outcomes[$];
    t_outcome want;

    int  mismatches = 0;
    int  loads_sent;
    int  coefficients_sent;
    int  results_checked = 0;
    int  idle_cycles;
    int  stall_left;
    int  next_stall;
    bit  feed_calm;
    bit  drain_calm;

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // expected word for one coefficient: round half away from zero, saturate
    function automatic t_outcome scale_coefficient(input logic [15:0] coef,
                                                   input logic [7:0] entry,
                                                   input logic [15:0] quality,
                                                   input logic dir);
        logic        neg;
        logic [16:0] mag;
        logic [23:0] step;
        logic [63:0] q;
        logic [63:0] limit;
        t_outcome    r;
        neg  = coef[15];
        mag  = neg ? (17'h10000 - {1'b0, coef}) : {1'b0, coef};
        step = entry * quality;
        r.status = ST_OK;
        if (dir == DIR_QUANT) begin
            if (step == 24'd0) begin
                r.status = ST_ZERO_DIV;
                if (mag == 17'd0) r.value = 16'h0000;
                else              r.value = neg ? MAG_NEG_LIMIT : MAG_POS_LIMIT;
                return r;
            end
            q = ((64'(mag) << 9) + 64'(step)) / (64'(step) << 1);
        end else begin
            q = (64'(mag) * 64'(step) + 64'd128) >> 8;
        end
        limit = neg ? 64'd32768 : 64'd32767;
        if (q > limit) begin
            q = limit;
            r.status = ST_SAT;
        end
        r.value = neg ? (16'd0 - q[15:0]) : q[15:0];
        return r;
    endfunction

    function automatic logic [15:0] pick_coefficient();
        int v;
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 4))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    3: return 16'h0001;
                    default: return 16'hFFFF;
                endcase
            end
            1, 2: begin
                v = $urandom_range(0, 600);
                return 16'(v - 300);
            end
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_quality();
        case ($urandom_range(0, 7))
            0: return 16'd1;
            1: return 16'hFFFF;
            2: return QUALITY_RESET;
            3, 4: return 16'($urandom_range(1, 512));
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    // send one word and note what it should cause
    task automatic send_word(input logic kind, input logic [1:0] channel,
                             input logic [2:0] row, input logic [2:0] col,
                             input logic [15:0] coef, input logic [7:0] word);
        int       gap;
        int       plane;
        int       slot;
        t_outcome expected;
        gap = feed_calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.req_type    <= kind;
        req_if.channel     <= channel;
        req_if.row         <= row;
        req_if.col         <= col;
        req_if.coefficient <= coef;
        req_if.table_word  <= word;
        do @(posedge i_clk); while (!req_if.ready);
        plane = (channel == CH_LUMA) ? 0 : 1;
        slot  = row * TABLE_DIM + col;
        if (kind == REQ_LOAD) begin
            table_copy[plane][slot] = word;
            loads_sent++;
        end else begin
            expected = scale_coefficient(coef, table_copy[plane][slot],
                                         quality_copy, direction_copy);
            pending_outcomes.insert(pending_outcomes.size(), expected);
            coefficients_sent++;
        end
    endtask

    // drop valid, wait for every result, then let the pipeline empty
    task automatic settle();
        req_if.valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic reg_sel, input logic [31:0] value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_QUALITY) quality_copy = value[15:0];
        else                        direction_copy = value[0];
    endtask

    // reset settings: unit scale, quantize, zero entries and both tables
    task automatic test_reset_settings();
        send_word(REQ_LOAD, CH_LUMA, 3'd0, 3'd0, 16'($urandom), 8'd16);
        send_word(REQ_LOAD, CH_CR,   3'd7, 3'd7, 16'($urandom), 8'd255);
        send_word(REQ_LOAD, CH_LUMA, 3'd7, 3'd0, 16'($urandom), 8'd0);
        send_word(REQ_LOAD, CH_CB,   3'd0, 3'd7, 16'($urandom), 8'd1);
        send_word(REQ_LOAD, CH_LUMA, 3'd3, 3'd4, 16'($urandom), 8'd3);
        send_word(REQ_PROC, CH_LUMA, 3'd0, 3'd0, 16'h7FFF, 8'($urandom));
        send_word(REQ_PROC, CH_LUMA, 3'd0, 3'd0, 16'h8000, 8'($urandom));
        // exact halves round away from zero
        send_word(REQ_PROC, CH_LUMA, 3'd0, 3'd0, 16'd8, 8'($urandom));
        send_word(REQ_PROC, CH_LUMA, 3'd0, 3'd0, 16'hFFF8, 8'($urandom));
        send_word(REQ_PROC, CH_LUMA, 3'd0, 3'd0, 16'h0000, 8'($urandom));
        send_word(REQ_PROC, CH_CR,   3'd7, 3'd7, 16'h8000, 8'($urandom));
        // zero entry divides by zero
        send_word(REQ_PROC, CH_LUMA, 3'd7, 3'd0, 16'd5, 8'($urandom));
        send_word(REQ_PROC, CH_LUMA, 3'd7, 3'd0, 16'hFFFB, 8'($urandom));
        send_word(REQ_PROC, CH_LUMA, 3'd7, 3'd0, 16'h0000, 8'($urandom));
        send_word(REQ_PROC, CH_CB,   3'd0, 3'd7, 16'h8000, 8'($urandom));
        send_word(REQ_PROC, CH_CB,   3'd0, 3'd7, 16'h7FFF, 8'($urandom));
    endtask

    // smallest scale pushes the largest quotients past 16 bits
    task automatic test_quantize_saturation();
        write_register(REG_QUALITY, 32'd1);
        send_word(REQ_PROC, CH_LUMA, 3'd0, 3'd0, 16'd100, 8'($urandom));
        send_word(REQ_PROC, CH_LUMA, 3'd0, 3'd0, 16'h7FFF, 8'($urandom));
        send_word(REQ_PROC, CH_LUMA, 3'd0, 3'd0, 16'h8000, 8'($urandom));
    endtask

    task automatic test_dequantize();
        write_register(REG_DIRECTION, {31'd0, DIR_DEQUANT});
        write_register(REG_QUALITY, {16'd0, QUALITY_RESET});
        send_word(REQ_PROC, CH_CB,   3'd0, 3'd7, 16'h8000, 8'($urandom));
        // zero product gives zero with no error
        send_word(REQ_PROC, CH_LUMA, 3'd7, 3'd0, 16'd1234, 8'($urandom));
        send_word(REQ_PROC, CH_LUMA, 3'd0, 3'd0, 16'd3000, 8'($urandom));
        write_register(REG_QUALITY, 32'h0000_FFFF);
        send_word(REQ_PROC, CH_LUMA, 3'd3, 3'd4, 16'd1, 8'($urandom));
        // step of one and a half
        write_register(REG_QUALITY, 32'd384);
        send_word(REQ_PROC, CH_CB, 3'd0, 3'd7, 16'd1, 8'($urandom));
        send_word(REQ_PROC, CH_CB, 3'd0, 3'd7, 16'hFFFF, 8'($urandom));
    endtask

    // load every entry of both tables
    task automatic test_table_fill();
        logic [7:0] word;
        for (int plane = 0; plane < 2; plane++) begin
            for (int slot = 0; slot < TABLE_DIM * TABLE_DIM; slot++) begin
                word = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom);
                send_word(REQ_LOAD, plane == 0 ? CH_LUMA : 2'($urandom_range(1, 2)),
                          3'(slot / TABLE_DIM), 3'(slot % TABLE_DIM),
                          16'($urandom), word);
            end
        end
    endtask

    // random settings per phase, mostly coefficients with reloads mixed in
    task automatic test_random_phases();
        logic [1:0] channel;
        logic [2:0] row;
        logic [2:0] col;
        logic [7:0] word;
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            write_register(REG_QUALITY, {16'd0, pick_quality()});
            write_register(REG_DIRECTION, {31'd0, 1'($urandom)});
            feed_calm  = ($urandom_range(0, 3) == 0);
            drain_calm = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                channel = 2'($urandom_range(0, 2));
                row     = 3'($urandom);
                col     = 3'($urandom);
                if ($urandom_range(0, 4) == 0) begin
                    word = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom);
                    send_word(REQ_LOAD, channel, row, col, 16'($urandom), word);
                end else begin
                    send_word(REQ_PROC, channel, row, col, pick_coefficient(),
                              8'($urandom));
                end
            end
        end
        feed_calm  = 1'b0;
        drain_calm = 1'b0;
    endtask

    // result ready with a random stall after each word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_left   <= 0;
        end else if (res_if.ready) begin
            if (res_if.valid) begin
                next_stall = drain_calm ? 0 : $urandom_range(0, 8);
                if (next_stall > 0) begin
                    res_if.ready <= 1'b0;
                    stall_left   <= next_stall;
                end
            end
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_checked++;
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: value %0d status %0d",
                             $signed(res_if.result_value), res_if.status);
            end else begin
                want = pending_outcomes.pop_front();
                if (res_if.result_value !== want.value || res_if.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected value %0d status %0d, %s %0d status %0d",
                                 $signed(want.value), want.status, "got value",
                                 $signed(res_if.result_value), res_if.status);
                end
            end
        end
    end

    // watchdog on cycles with no traffic
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || psel)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout with %0d results outstanding", pending_outcomes.size());
                $display("testbench failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        req_if.valid       <= 1'b0;
        req_if.req_type    <= REQ_LOAD;
        req_if.channel     <= CH_LUMA;
        req_if.row         <= '0;
        req_if.col         <= '0;
        req_if.coefficient <= '0;
        req_if.table_word  <= '0;
        loads_sent         = 0;
        coefficients_sent  = 0;
        feed_calm          = 1'b0;
        drain_calm         = 1'b0;
        quality_copy       = QUALITY_RESET;
        direction_copy     = DIR_QUANT;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_settings();
        test_quantize_saturation();
        test_dequantize();
        test_table_fill();
        test_random_phases();
        settle();

        $display("sent %0d table loads and %0d coefficients, checked %0d results",
                 loads_sent, coefficients_sent, results_checked);
        $display("covered both directions over %0d scale settings with random stalls",
                 PHASE_COUNT + 4);
        if (mismatches == 0 && pending_outcomes.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     pending_outcomes.size());
            $display("testbench failed");
        end
        $finish;
    end

endmodule
